// File: hdl/sh24_pkg.sv
package sh24_pkg;

	// Widths of the item fields and the key registers.
	localparam int unsigned WORD_W  = 64;
	localparam int unsigned COUNT_W = 4;
	localparam int unsigned LEN_W   = 8;
	localparam int unsigned BYTES   = WORD_W / 8;
	localparam int unsigned CFG_IDX_W = 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

	// Initialisation constants of the four lanes.
	localparam logic [WORD_W-1:0] IV_A = 64'h736f6d6570736575;
	localparam logic [WORD_W-1:0] IV_B = 64'h646f72616e646f6d;
	localparam logic [WORD_W-1:0] IV_C = 64'h6c7967656e657261;
	localparam logic [WORD_W-1:0] IV_D = 64'h7465646279746573;

	// Value folded into lane c before the finalisation rounds.
	localparam logic [WORD_W-1:0] FINAL_MARK = 64'h00000000000000ff;

	// Count of full bytes in a word, as carried by valid_bytes.
	localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

	// The internal hash state.
	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
	} lanes_t;

endpackage

// File: hdl/sh24_if.sv
// Input channel: one message word per item.
interface sh24_in_if;
	logic                           valid;
	logic                           ready;
	logic [sh24_pkg::WORD_W-1:0]    message_word;
	logic [sh24_pkg::COUNT_W-1:0]   valid_bytes;
	logic                           last_word;

	modport source (output valid, message_word, valid_bytes, last_word, input ready);
	modport sink   (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

// Output channel: one hash value per item.
interface sh24_out_if;
	logic                           valid;
	logic                           ready;
	logic [sh24_pkg::WORD_W-1:0]    hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink   (input valid, hash_value, output ready);
endinterface

// File: hdl/sh24_round.sv
module sh24_round (
	input  sh24_pkg::lanes_t lanes_in,
	output sh24_pkg::lanes_t lanes_out
);
	import sh24_pkg::*;

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
			input int unsigned n);
		return (x << n) | (x >> (WORD_W - n));
	endfunction

	logic [WORD_W-1:0] a1, a2, a3, b1, b2, c1, c2, d1;

	// One full mixing round: two add, rotate and xor halves.
	always_comb begin
		c1 = lanes_in.c + lanes_in.d;
		d1 = rotl(lanes_in.d, 16) ^ c1;
		a1 = lanes_in.a + lanes_in.b;
		b1 = rotl(lanes_in.b, 13) ^ a1;
		a2 = rotl(a1, 32);
		c2 = c1 + b1;
		a3 = a2 + d1;
		b2 = rotl(b1, 17) ^ c2;
		lanes_out.a = a3;
		lanes_out.b = b2;
		lanes_out.c = rotl(c2, 32);
		lanes_out.d = rotl(d1, 21) ^ a3;
	end

endmodule

// File: hdl/siphash_2_4_keyed_hash_core.sv
// A non-last word is loaded, then takes two passes of the round unit.
// A last word of 8 bytes adds a length-only tail block; every last word is then finalised.
// One round unit is shared over all rounds, one round a cycle; one word is in work at a time.
// A finished result waits in the output register while the next word is taken.
// Reset (arst_n low) clears both key registers, the sequencer and the message state.
module siphash_2_4_keyed_hash_core (
	input  logic                               clk,
	input  logic                               arst_n,
	sh24_in_if.sink                            in_ch,
	sh24_out_if.source                         out_ch,
	input  logic                               cfg_wr_en,
	input  logic [sh24_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sh24_pkg::WORD_W-1:0]        cfg_data
);
	import sh24_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_COMP = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t            state_q;
	logic [1:0]        rcnt_q;
	logic              in_msg_q;
	logic              tail_pend_q;
	logic              final_q;
	logic [LEN_W-1:0]  len_q;
	logic [WORD_W-1:0] blk_q;
	logic [WORD_W-1:0] key_low_q;
	logic [WORD_W-1:0] key_high_q;
	lanes_t            lanes_q;
	lanes_t            rnd_out;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_hash_q;

	logic              accept;
	logic              slot_free;
	lanes_t            base;
	logic [COUNT_W-1:0] cnt_sat;
	logic [COUNT_W-1:0] len_add;
	logic [LEN_W-1:0]  len_new;
	logic [WORD_W-1:0] byte_mask;
	logic [WORD_W-1:0] first_blk;
	logic [WORD_W-1:0] tail_blk;
	lanes_t            comp_end;

	// Shared round unit.
	sh24_round u_round (
		.lanes_in  (lanes_q),
		.lanes_out (rnd_out)
	);

	assign in_ch.ready       = (state_q == ST_IDLE);
	assign accept            = in_ch.valid && in_ch.ready;
	assign slot_free         = !out_valid_q || out_ch.ready;
	assign out_ch.valid      = out_valid_q;
	assign out_ch.hash_value = out_hash_q;

	// Key registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_KEY_HIGH: key_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Block set-up at acceptance: lanes of a new message, length and first block.
	always_comb begin
		if (in_msg_q) begin
			base = lanes_q;
		end else begin
			base.a = key_low_q ^ IV_A;
			base.b = key_high_q ^ IV_B;
			base.c = key_low_q ^ IV_C;
			base.d = key_high_q ^ IV_D;
		end
		cnt_sat = (in_ch.valid_bytes > FULL_COUNT) ? FULL_COUNT : in_ch.valid_bytes;
		len_add = in_ch.last_word ? cnt_sat : FULL_COUNT;
		len_new = (in_msg_q ? len_q : '0) + {{(LEN_W-COUNT_W){1'b0}}, len_add};
		for (int i = 0; i < BYTES; i++) begin
			byte_mask[i*8 +: 8] = (COUNT_W'(i) < cnt_sat) ? 8'hff : 8'h00;
		end
		if (in_ch.last_word && (cnt_sat != FULL_COUNT)) begin
			first_blk = (in_ch.message_word & byte_mask)
				| {len_new, {(WORD_W-LEN_W){1'b0}}};
		end else begin
			first_blk = in_ch.message_word;
		end
	end

	// End of a compression: fold the block into lane a; for a last word, then either
	// start the length-only tail block or mark lane c for finalisation.
	assign tail_blk = {len_q, {(WORD_W-LEN_W){1'b0}}};
	always_comb begin
		comp_end   = rnd_out;
		comp_end.a = rnd_out.a ^ blk_q;
		if (tail_pend_q) begin
			comp_end.d = rnd_out.d ^ tail_blk;
		end else if (final_q) begin
			comp_end.c = rnd_out.c ^ FINAL_MARK;
		end
	end

	// Output register flag: raised when a result is loaded, dropped once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer and hash state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rcnt_q      <= '0;
			in_msg_q    <= 1'b0;
			tail_pend_q <= 1'b0;
			final_q     <= 1'b0;
			len_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						in_msg_q    <= 1'b1;
						len_q       <= len_new;
						tail_pend_q <= in_ch.last_word && (cnt_sat == FULL_COUNT);
						final_q     <= in_ch.last_word;
						rcnt_q      <= '0;
						state_q     <= ST_COMP;
					end
				end
				ST_COMP: begin
					if (rcnt_q == 2'd1) begin
						rcnt_q <= '0;
						if (tail_pend_q) begin
							tail_pend_q <= 1'b0;
						end else if (final_q) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						rcnt_q <= rcnt_q + 2'd1;
					end
				end
				ST_FIN: begin
					rcnt_q <= rcnt_q + 2'd1;
					if (rcnt_q == 2'd3) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						in_msg_q    <= 1'b0;
						final_q     <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Lanes, current block and result register carry no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					lanes_q <= '{a: base.a, b: base.b, c: base.c, d: base.d ^ first_blk};
					blk_q   <= first_blk;
				end
			end
			ST_COMP: begin
				if (rcnt_q == 2'd1) begin
					lanes_q <= comp_end;
					if (tail_pend_q) begin
						blk_q <= tail_blk;
					end
				end else begin
					lanes_q <= rnd_out;
				end
			end
			ST_FIN: begin
				lanes_q <= rnd_out;
			end
			ST_DONE: begin
				if (slot_free) begin
					out_hash_q <= lanes_q.a ^ lanes_q.b ^ lanes_q.c ^ lanes_q.d;
				end
			end
			default: ;
		endcase
	end

	// A result appears only after the finalisation rounds have run.
	a_out_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	// Finalisation only runs for a last word whose tail block is done.
	a_fin_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (final_q && !tail_pend_q))
		else $error("finalisation entered with a block outstanding");

	// A compression takes two rounds, never more.
	a_comp_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP) |-> !rcnt_q[1])
		else $error("round count overran in compression");

	// An accepted item always leaves a message open.
	a_msg_open: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_msg_q)
		else $error("message not opened by an accepted item");

endmodule
